FILE: hw/rtl/lags_pkg.sv
// Shared types, constants and helper functions for the affine-gap local alignment scorer.
// No dependencies; every other file of the block imports this package.
package lags_pkg;

    localparam int MAX_SUBJECT_DEF = 256;
    localparam int SCORE_BITS_DEF  = 16;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;

    localparam logic [63:0]        SCORE_TABLE_RST = 64'h1EEE_E1EE_EE1E_EEE1;
    localparam logic signed [4:0]  GAP_OPEN_RST    = -5'sd4;
    localparam logic signed [4:0]  GAP_EXTEND_RST  = -5'sd3;

    typedef enum logic [1:0] {
        REG_SCORE_TABLE = 2'd0,
        REG_GAP_OPEN    = 2'd1,
        REG_GAP_EXTEND  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        BASE_A = 3'd0,
        BASE_C = 3'd1,
        BASE_G = 3'd2,
        BASE_T = 3'd3,
        BASE_N = 3'd4
    } base_t;

    typedef struct packed {
        logic       func;
        logic [7:0] base_byte;
        logic       first;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [15:0] best_score;
        logic        subject_overflow;
    } result_t;

    // Control that travels with one query base along the row of cells
    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        base_t code;
    } tok_t;

    typedef struct packed {
        logic [63:0]       score_table;
        logic signed [4:0] gap_open;
        logic signed [4:0] gap_extend;
    } cfg_t;

    function automatic base_t base_code(input logic [7:0] b);
        base_t r;
        if (b inside {8'h41, 8'h61, 8'h55, 8'h75})
            r = BASE_A;
        else if (b inside {8'h43, 8'h63})
            r = BASE_C;
        else if (b inside {8'h47, 8'h67})
            r = BASE_G;
        else if (b inside {8'h54, 8'h74})
            r = BASE_T;
        else
            r = BASE_N;
        return r;
    endfunction

    // Any pairing with N scores zero
    function automatic logic signed [3:0] sub_score(input logic [63:0] tbl,
                                                    input base_t s, input base_t q);
        logic [5:0]        sel;
        logic signed [3:0] r;
        sel = {s[1:0], q[1:0], 2'b00};
        if (s[2] || q[2])
            r = 4'sd0;
        else
            r = tbl[sel +: 4];
        return r;
    endfunction

endpackage

FILE: hw/rtl/local_alignment_affine_gap_score.sv
// A query byte with last crosses the MAX_SUBJECT cell registers, then the result register.
// Throughput: one query byte per cycle through the row of MAX_SUBJECT cells while the row
// advances and no register write waits; one subject byte per cycle once the row is empty.
// A register write holds input until the row is empty, then takes effect.
// Reset: asynchronous, active low; clears lengths, flags, score rows (gap row to -1), the
// running best and the registers to their defaults. Subject contents are not cleared.
module local_alignment_affine_gap_score
    import lags_pkg::*;
#(
    parameter int MAX_SUBJECT = MAX_SUBJECT_DEF,
    parameter int SCORE_BITS  = SCORE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int LEN_W = $clog2(MAX_SUBJECT + 1);
    localparam int BW    = (SCORE_BITS > 16) ? SCORE_BITS : 16;

    cfg_t                      cfg;
    logic                      cfg_pending;
    logic                      drained;
    logic                      advance;
    logic                      accept, q_acc, s_acc;

    tok_t                      tok_link [MAX_SUBJECT+1];
    logic [SCORE_BITS-1:0]     h_link   [MAX_SUBJECT+1];
    logic signed [SCORE_BITS:0] e_link  [MAX_SUBJECT+1];
    logic [SCORE_BITS-1:0]     d_link   [MAX_SUBJECT+1];
    logic [SCORE_BITS-1:0]     m_link   [MAX_SUBJECT+1];

    logic [LEN_W-1:0]          len_reg, len_next, len_base;
    logic                      ov_reg, ov_next, ov_base;
    logic                      subj_we;
    base_t                     in_code;
    logic [LEN_W-1:0]          inflight_reg, inflight_next;
    logic [SCORE_BITS-1:0]     best_reg, best_next, best_row;
    logic [BW-1:0]             best_wide;
    logic                      end_take;
    logic                      result_valid_reg, result_valid_next;
    result_t                   result_reg, result_next;

    lags_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .drained (drained),
        .cfg     (cfg),
        .pending (cfg_pending)
    );

    assign drained  = (inflight_reg == '0);
    // Hold the whole row while a result sits at its end and the output is still full
    assign advance  = !(tok_link[MAX_SUBJECT].valid && tok_link[MAX_SUBJECT].last &&
                        result_valid_reg && !result_ready);
    assign item_ready = advance && !cfg_pending && (item.func || drained);
    assign accept   = item_valid && item_ready;
    assign q_acc    = accept && item.func;
    assign s_acc    = accept && !item.func;
    assign in_code  = base_code(item.base_byte);
    assign end_take = advance && tok_link[MAX_SUBJECT].valid;

    always_comb
    begin
        tok_link[0].valid = q_acc;
        tok_link[0].first = item.first;
        tok_link[0].last  = item.last;
        tok_link[0].code  = in_code;
        h_link[0]         = '0;
        e_link[0]         = {1'b1, {SCORE_BITS{1'b0}}};
        d_link[0]         = '0;
        m_link[0]         = '0;
    end

    for (genvar j = 0; j < MAX_SUBJECT; j++)
    begin : g_cell
        lags_cell #(
            .SCORE_BITS (SCORE_BITS),
            .LEN_W      (LEN_W),
            .INDEX      (j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (cfg),
            .subj_we   (subj_we),
            .subj_addr (len_base),
            .subj_code (in_code),
            .subj_len  (len_reg),
            .tok_in    (tok_link[j]),
            .h_in      (h_link[j]),
            .e_in      (e_link[j]),
            .d_in      (d_link[j]),
            .m_in      (m_link[j]),
            .tok_out   (tok_link[j+1]),
            .h_out     (h_link[j+1]),
            .e_out     (e_link[j+1]),
            .d_out     (d_link[j+1]),
            .m_out     (m_link[j+1])
        );
    end

    // Subject load bookkeeping
    always_comb
    begin
        len_base = item.first ? '0 : len_reg;
        ov_base  = item.first ? 1'b0 : ov_reg;
        subj_we  = 1'b0;
        len_next = len_reg;
        ov_next  = ov_reg;
        if (s_acc)
        begin
            if (len_base < LEN_W'(MAX_SUBJECT))
            begin
                subj_we  = 1'b1;
                len_next = len_base + 1'b1;
                ov_next  = ov_base;
            end
            else
            begin
                len_next = len_base;
                ov_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (q_acc && !end_take)
            inflight_next = inflight_reg + 1'b1;
        else if (!q_acc && end_take)
            inflight_next = inflight_reg - 1'b1;
    end

    // Fold each row maximum into the running best; a first query restarts it
    always_comb
    begin
        best_row = m_link[MAX_SUBJECT];
        if (tok_link[MAX_SUBJECT].first)
            best_next = best_row;
        else
            best_next = (best_row > best_reg) ? best_row : best_reg;
        best_wide = BW'(best_next);
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        if (end_take && tok_link[MAX_SUBJECT].last)
        begin
            result_valid_next            = 1'b1;
            result_next.best_score       = (best_wide > BW'(16'hFFFF)) ? 16'hFFFF :
                                           best_wide[15:0];
            result_next.subject_overflow = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            ov_reg           <= 1'b0;
            inflight_reg     <= '0;
            best_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            ov_reg           <= ov_next;
            inflight_reg     <= inflight_next;
            if (end_take)
                best_reg     <= best_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/lags_cfg.sv
// APB register file for the scorer: score table and the two gap costs.
// Holds written values and copies them to the working set once the cell row is empty.
// Depends on lags_pkg.
module lags_cfg
    import lags_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              drained,
    output cfg_t              cfg,
    output logic              pending
);

    logic [63:0]       table_reg, table_next;
    logic signed [4:0] open_reg, open_next;
    logic signed [4:0] ext_reg, ext_next;
    cfg_t              cfg_reg, cfg_next;
    logic              pending_reg, pending_next;
    logic              wr;
    reg_idx_t          idx;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign pending = pending_reg;

    always_comb
    begin
        table_next   = table_reg;
        open_next    = open_reg;
        ext_next     = ext_reg;
        cfg_next     = cfg_reg;
        pending_next = pending_reg;
        // Apply the held values only when no transaction is inside the cell row
        if (pending_reg && drained)
        begin
            cfg_next.score_table = table_reg;
            cfg_next.gap_open    = open_reg;
            cfg_next.gap_extend  = ext_reg;
            pending_next         = 1'b0;
        end
        if (wr)
        begin
            case (idx)
                REG_SCORE_TABLE:
                begin
                    table_next   = pwdata[63:0];
                    pending_next = 1'b1;
                end
                REG_GAP_OPEN:
                begin
                    open_next    = pwdata[4:0];
                    pending_next = 1'b1;
                end
                REG_GAP_EXTEND:
                begin
                    ext_next     = pwdata[4:0];
                    pending_next = 1'b1;
                end
                default:
                begin
                    table_next = table_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SCORE_TABLE: prdata = table_reg;
            REG_GAP_OPEN:    prdata = {59'd0, open_reg};
            REG_GAP_EXTEND:  prdata = {59'd0, ext_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg           <= SCORE_TABLE_RST;
            open_reg            <= GAP_OPEN_RST;
            ext_reg             <= GAP_EXTEND_RST;
            cfg_reg.score_table <= SCORE_TABLE_RST;
            cfg_reg.gap_open    <= GAP_OPEN_RST;
            cfg_reg.gap_extend  <= GAP_EXTEND_RST;
            pending_reg         <= 1'b0;
        end
        else
        begin
            table_reg   <= table_next;
            open_reg    <= open_next;
            ext_reg     <= ext_next;
            cfg_reg     <= cfg_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: hw/rtl/lags_cell.sv
// One cell of the systolic row: holds one subject base, its best score and vertical gap.
// Computes one matrix cell per query base and hands score, gap, diagonal and max onward.
// Depends on lags_pkg.
module lags_cell
    import lags_pkg::*;
#(
    parameter int SCORE_BITS = SCORE_BITS_DEF,
    parameter int LEN_W      = 9,
    parameter int INDEX      = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  cfg_t                   cfg,
    input  logic                   subj_we,
    input  logic [LEN_W-1:0]       subj_addr,
    input  base_t                  subj_code,
    input  logic [LEN_W-1:0]       subj_len,
    input  tok_t                   tok_in,
    input  logic [SCORE_BITS-1:0]  h_in,
    input  logic signed [SCORE_BITS:0] e_in,
    input  logic [SCORE_BITS-1:0]  d_in,
    input  logic [SCORE_BITS-1:0]  m_in,
    output tok_t                   tok_out,
    output logic [SCORE_BITS-1:0]  h_out,
    output logic signed [SCORE_BITS:0] e_out,
    output logic [SCORE_BITS-1:0]  d_out,
    output logic [SCORE_BITS-1:0]  m_out
);

    localparam int W = SCORE_BITS + 2;
    localparam logic signed [W-1:0] SMAX = {2'b00, {SCORE_BITS{1'b1}}};

    logic [SCORE_BITS-1:0]     h_reg, h_next;
    logic signed [SCORE_BITS:0] v_reg, v_next;
    base_t                     subj_reg, subj_next;
    tok_t                      tok_reg, tok_next;
    logic [SCORE_BITS-1:0]     ho_reg, ho_next;
    logic signed [SCORE_BITS:0] eo_reg, eo_next;
    logic [SCORE_BITS-1:0]     do_reg, do_next;
    logic [SCORE_BITS-1:0]     mo_reg, mo_next;

    logic                      active;
    logic signed [4:0]         open_c, ext_c;
    logic signed [3:0]         sub_val;
    logic signed [W-1:0]       above, vert, up_open, up_ext, t_raw, t_sat;
    logic signed [W-1:0]       left_h, left_open, left_ext, lg_raw, lg_sat;
    logic signed [W-1:0]       diag_w, diag_sum, best_a, best_b, cell_raw, cell_sat;
    logic [SCORE_BITS-1:0]     cell_val, max_val;

    assign open_c  = cfg.gap_open;
    assign ext_c   = cfg.gap_extend;
    assign active  = (subj_len > LEN_W'(INDEX));
    assign sub_val = sub_score(cfg.score_table, subj_reg, tok_in.code);

    always_comb
    begin
        above     = tok_in.first ? '0 : {2'b00, h_reg};
        vert      = tok_in.first ? {W{1'b1}} : W'(v_reg);
        up_open   = above + W'(open_c);
        up_ext    = vert + W'(ext_c);
        t_raw     = (up_open > up_ext) ? up_open : up_ext;
        t_sat     = (t_raw > SMAX) ? SMAX : t_raw;

        left_h    = {2'b00, h_in};
        left_open = left_h + W'(open_c);
        left_ext  = W'(e_in) + W'(ext_c);
        lg_raw    = (left_open > left_ext) ? left_open : left_ext;
        lg_sat    = (lg_raw > SMAX) ? SMAX : lg_raw;

        diag_w    = {2'b00, d_in};
        diag_sum  = diag_w + W'(sub_val);
        best_a    = (diag_sum > 0) ? diag_sum : '0;
        best_b    = (t_sat > lg_sat) ? t_sat : lg_sat;
        cell_raw  = (best_a > best_b) ? best_a : best_b;
        cell_sat  = (cell_raw > SMAX) ? SMAX : cell_raw;
        cell_val  = cell_sat[SCORE_BITS-1:0];
        max_val   = (cell_val > m_in) ? cell_val : m_in;
    end

    always_comb
    begin
        h_next    = h_reg;
        v_next    = v_reg;
        subj_next = subj_reg;
        tok_next  = tok_reg;
        ho_next   = ho_reg;
        eo_next   = eo_reg;
        do_next   = do_reg;
        mo_next   = mo_reg;
        if (subj_we && (subj_addr == LEN_W'(INDEX)))
            subj_next = subj_code;
        if (advance)
        begin
            tok_next = tok_in;
            ho_next  = cell_val;
            eo_next  = lg_sat[SCORE_BITS:0];
            do_next  = above[SCORE_BITS-1:0];
            mo_next  = active ? max_val : m_in;
            if (tok_in.valid)
            begin
                if (active)
                begin
                    h_next = cell_val;
                    v_next = t_sat[SCORE_BITS:0];
                end
                else if (tok_in.first)
                begin
                    // Cells past the subject still take the row clear
                    h_next = '0;
                    v_next = '1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= '0;
            v_reg   <= '1;
            tok_reg <= '0;
        end
        else
        begin
            h_reg   <= h_next;
            v_reg   <= v_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        subj_reg <= subj_next;
        ho_reg   <= ho_next;
        eo_reg   <= eo_next;
        do_reg   <= do_next;
        mo_reg   <= mo_next;
    end

    assign tok_out = tok_reg;
    assign h_out   = ho_reg;
    assign e_out   = eo_reg;
    assign d_out   = do_reg;
    assign m_out   = mo_reg;

endmodule

FILE: hw/rtl/lags_checker.sv
// Port-level checks for the affine-gap local alignment scorer, bound to its top level.
// Depends on lags_pkg and local_alignment_affine_gap_score.
module lags_checker
    import lags_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input result_t           result,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata
);

    // A result transaction stays offered until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result_valid dropped before the transaction completed");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result_valid high right after reset");

    // A score table write reads back on the next cycle
    a_table_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (reg_idx_t'(paddr[ADDR_W-1:3]) == REG_SCORE_TABLE)
        |=> (reg_idx_t'(paddr[ADDR_W-1:3]) != REG_SCORE_TABLE) || (prdata == $past(pwdata)))
        else $error("score table read back differs from the value written");

endmodule

bind local_alignment_affine_gap_score lags_checker u_lags_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

FILE: tb/tb_local_alignment_affine_gap_score.sv
// Testbench for local_alignment_affine_gap_score: subject loads and query streams are
// scored by an in-bench affine-gap predictor and every result is checked against it.
// Depends on lags_pkg (payload structs, register indexes, base codes) and the RTL top.
module tb_local_alignment_affine_gap_score;
    import lags_pkg::*;

    localparam int    MAX_SUBJ     = 256;
    localparam int    SCORE_CAP    = 65535;
    localparam int    IDLE_MAX     = 18;
    localparam int    HOLD_CYCLES  = 3000;
    localparam int    SETTLE_LIMIT = 40000;
    localparam int    CYCLE_LIMIT  = 3000000;
    localparam int    PRINT_LIMIT  = 60;
    localparam logic  FUNC_SUBJECT = 1'b0;
    localparam logic  FUNC_QUERY   = 1'b1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    item_t             item;
    logic              result_valid;
    logic              result_ready;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor copy of the registers and the alignment state
    logic [63:0] cfg_table;
    int          cfg_open;
    int          cfg_ext;
    base_t       subj_code [MAX_SUBJ];
    int          subj_len;
    bit          ovf_seen;
    int          cell_row [MAX_SUBJ];
    int          vgap_row [MAX_SUBJ];
    int          run_best;

    result_t     pending_scores [$];
    int          errors = 0;
    int          items_accepted = 0;
    int          scores_checked = 0;
    int          cycle_count = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    logic        hold_req;
    int          hold_left = 0;

    local_alignment_affine_gap_score dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic int draw_gap(input bit enabled);
        if (!enabled)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic base_t letter_code(input logic [7:0] b);
        case (b)
            "A", "a", "U", "u": return BASE_A;
            "C", "c":           return BASE_C;
            "G", "g":           return BASE_G;
            "T", "t":           return BASE_T;
            default:            return BASE_N;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 13))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            3:       return "T";
            4:       return "a";
            5:       return "c";
            6:       return "g";
            7:       return "t";
            8:       return "U";
            9:       return "u";
            10:      return "N";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pair_score(input base_t s, input base_t q);
        logic [3:0] nib;
        if (s == BASE_N || q == BASE_N)
            return 0;
        nib = cfg_table[4 * (4 * int'(s) + int'(q)) +: 4];
        return int'($signed(nib));
    endfunction

    function automatic int max_of(input int a, input int b);
        return a > b ? a : b;
    endfunction

    function automatic int clip(input int v);
        return v > SCORE_CAP ? SCORE_CAP : v;
    endfunction

    function automatic item_t pack_item(input logic f, input logic [7:0] b,
                                        input logic fi, input logic la);
        item_t it;
        it.func      = f;
        it.base_byte = b;
        it.first     = fi;
        it.last      = la;
        return it;
    endfunction

    task automatic reset_rows();
        for (int j = 0; j < MAX_SUBJ; j++)
        begin
            cell_row[j] = 0;
            vgap_row[j] = -1;
        end
        run_best = 0;
    endtask

    // Apply one accepted transaction to the alignment state
    task automatic advance_alignment(input item_t it);
        base_t   code;
        int      diag;
        int      left;
        int      above;
        int      t;
        int      s;
        int      c;
        result_t r;
        code = letter_code(it.base_byte);
        if (it.func == FUNC_SUBJECT)
        begin
            if (it.first)
            begin
                subj_len = 0;
                ovf_seen = 1'b0;
            end
            if (subj_len < MAX_SUBJ)
            begin
                subj_code[subj_len] = code;
                subj_len++;
            end
            else
                ovf_seen = 1'b1;
        end
        else
        begin
            if (it.first)
                reset_rows();
            diag = 0;
            left = 0;
            for (int j = 0; j < subj_len; j++)
            begin
                above = cell_row[j];
                t = clip(max_of(above + cfg_open, vgap_row[j] + cfg_ext));
                vgap_row[j] = t;
                if (j == 0)
                    left = clip(cfg_open);
                else
                    left = clip(max_of(cell_row[j - 1] + cfg_open, left + cfg_ext));
                s = diag + pair_score(subj_code[j], code);
                diag = above;
                c = clip(max_of(max_of(0, s), max_of(t, left)));
                cell_row[j] = c;
                run_best = max_of(run_best, c);
            end
            if (it.last)
            begin
                r.best_score       = 16'(run_best > 65535 ? 65535 : run_best);
                r.subject_overflow = ovf_seen;
                pending_scores.push_back(r);
            end
        end
    endtask

    task automatic send_item(input item_t it);
        int gap;
        gap = draw_gap(src_idle_on);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_accepted++;
        advance_alignment(it);
    endtask

    // Send count bytes of random letters, first/last marking the ends
    task automatic send_run(input logic f, input int count, input bit with_first,
                            input bit with_last);
        for (int k = 0; k < count; k++)
            send_item(pack_item(f, pick_letter(), with_first && k == 0,
                                with_last && k == count - 1));
    endtask

    // Drop valid, wait for outstanding scores, then let the row empty
    task automatic settle();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (pending_scores.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (MAX_SUBJ + 32) @(posedge clk);
    endtask

    task automatic apb_xfer(input reg_idx_t idx, input logic wr, input logic [63:0] wdata,
                            output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [63:0] want,
                             input logic [63:0] mask);
        logic [63:0] got;
        apb_xfer(idx, 1'b0, 64'd0, got);
        if ((got & mask) != (want & mask))
        begin
            errors++;
            if (errors < PRINT_LIMIT)
                $display("%0t: register %0d expected %h got %h", $time, idx,
                         want & mask, got & mask);
        end
    endtask

    task automatic set_config(input logic [63:0] tbl, input logic [4:0] gopen,
                              input logic [4:0] gext);
        logic [63:0] unused;
        settle();
        apb_xfer(REG_SCORE_TABLE, 1'b1, tbl, unused);
        apb_xfer(REG_GAP_OPEN, 1'b1, {59'd0, gopen}, unused);
        apb_xfer(REG_GAP_EXTEND, 1'b1, {59'd0, gext}, unused);
        cfg_table = tbl;
        cfg_open  = int'($signed(gopen));
        cfg_ext   = int'($signed(gext));
        check_reg(REG_SCORE_TABLE, tbl, {64{1'b1}});
        check_reg(REG_GAP_OPEN, {59'd0, gopen}, 64'h1F);
        check_reg(REG_GAP_EXTEND, {59'd0, gext}, 64'h1F);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random ready gaps, long hold when requested, compare in order
    initial
    begin
        int      gap;
        result_t want;
        result_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = draw_gap(sink_idle_on);
            if (gap > 0 || hold_left != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_left != 0)
                    @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            scores_checked++;
            if (pending_scores.size() == 0)
            begin
                errors++;
                if (errors < PRINT_LIMIT)
                    $display("%0t: unexpected result expected none got score %0d ovf %0b",
                             $time, result.best_score, result.subject_overflow);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (result.best_score !== want.best_score)
                begin
                    errors++;
                    if (errors < PRINT_LIMIT)
                        $display("%0t: best_score expected %0d got %0d", $time,
                                 want.best_score, result.best_score);
                end
                if (result.subject_overflow !== want.subject_overflow)
                begin
                    errors++;
                    if (errors < PRINT_LIMIT)
                        $display("%0t: subject_overflow expected %0b got %0b", $time,
                                 want.subject_overflow, result.subject_overflow);
                end
            end
        end
    end

    task automatic test_empty_subject();
        send_item(pack_item(FUNC_QUERY, "A", 1'b0, 1'b1));
        send_item(pack_item(FUNC_QUERY, "G", 1'b1, 1'b1));
    endtask

    task automatic test_basic_letters();
        send_item(pack_item(FUNC_SUBJECT, "A", 1'b1, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, "c", 1'b0, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, "G", 1'b0, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, "t", 1'b0, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, "U", 1'b0, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, "n", 1'b0, 1'b0));
        send_item(pack_item(FUNC_SUBJECT, 8'hFF, 1'b0, 1'b0));
        // last on a subject byte produces nothing
        send_item(pack_item(FUNC_SUBJECT, "g", 1'b0, 1'b1));
        send_item(pack_item(FUNC_QUERY, "a", 1'b1, 1'b0));
        send_item(pack_item(FUNC_QUERY, "C", 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, "g", 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, "T", 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, "u", 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, 8'h00, 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, "A", 1'b0, 1'b1));
        // continue the rows without a new start
        send_item(pack_item(FUNC_QUERY, "G", 1'b0, 1'b0));
        send_item(pack_item(FUNC_QUERY, "c", 1'b0, 1'b1));
        send_item(pack_item(FUNC_QUERY, "t", 1'b1, 1'b1));
    endtask

    task automatic test_register_extremes();
        set_config(64'h7777_7777_7777_7777, 5'd0, 5'd0);
        send_run(FUNC_SUBJECT, 6, 1'b1, 1'b0);
        send_run(FUNC_QUERY, 6, 1'b1, 1'b1);
        set_config(64'h8888_8888_8888_8888, 5'h11, 5'h11);
        send_run(FUNC_QUERY, 6, 1'b1, 1'b1);
        set_config(64'h0000_0000_0000_0000, 5'h10, 5'h10);
        send_run(FUNC_QUERY, 6, 1'b1, 1'b1);
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 5'd15, 5'd15);
        send_run(FUNC_QUERY, 6, 1'b1, 1'b1);
        set_config(SCORE_TABLE_RST, GAP_OPEN_RST, GAP_EXTEND_RST);
        send_run(FUNC_QUERY, 6, 1'b1, 1'b1);
    endtask

    task automatic test_subject_overflow();
        send_run(FUNC_SUBJECT, MAX_SUBJ, 1'b1, 1'b0);
        send_run(FUNC_QUERY, 8, 1'b1, 1'b1);
        send_run(FUNC_SUBJECT, MAX_SUBJ + 3, 1'b1, 1'b0);
        send_run(FUNC_QUERY, 12, 1'b1, 1'b1);
        // a new start clears the flag
        send_run(FUNC_SUBJECT, 3, 1'b1, 1'b0);
        send_run(FUNC_QUERY, 4, 1'b1, 1'b1);
    endtask

    task automatic test_score_saturation();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_config(64'h7777_7777_7777_7777, 5'd15, 5'd15);
        for (int k = 0; k < MAX_SUBJ; k++)
            send_item(pack_item(FUNC_SUBJECT, "A", k == 0, 1'b0));
        for (int k = 0; k < 4300; k++)
            send_item(pack_item(FUNC_QUERY, "A", k == 0, k % 1000 == 999 || k == 4299));
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_config(SCORE_TABLE_RST, GAP_OPEN_RST, GAP_EXTEND_RST);
        send_run(FUNC_SUBJECT, 8, 1'b1, 1'b0);
        src_idle_on = 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        // keep offering single-byte queries while results are held back
        for (int k = 0; k < 400; k++)
            send_item(pack_item(FUNC_QUERY, pick_letter(), 1'b1, 1'b1));
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          base_items;
        int          base_scores;
        int          last_cfg;
        int          kind;
        int          len;
        int          v;
        logic [4:0]  gopen;
        logic [4:0]  gext;
        base_items  = items_accepted;
        base_scores = scores_checked;
        last_cfg    = items_accepted;
        while (items_accepted - base_items < 1600 || scores_checked - base_scores < 48)
        begin
            if (items_accepted - last_cfg >= 200)
            begin
                v = $urandom_range(0, 15);
                gopen = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'(-v);
                v = $urandom_range(0, 15);
                gext = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'(-v);
                set_config({$urandom(), $urandom()}, gopen, gext);
                last_cfg = items_accepted;
            end
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 19);
            if (kind <= 3)
            begin
                v = $urandom_range(0, 19);
                if (v < 16)
                    len = $urandom_range(1, 16);
                else if (v < 19)
                    len = $urandom_range(17, MAX_SUBJ);
                else
                    len = $urandom_range(MAX_SUBJ + 1, MAX_SUBJ + 8);
                for (int k = 0; k < len; k++)
                    send_item(pack_item(FUNC_SUBJECT, pick_letter(), k == 0,
                                        1'($urandom_range(0, 1))));
            end
            else if (kind <= 15)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                   : $urandom_range(1, 24);
                for (int k = 0; k < len; k++)
                    send_item(pack_item(FUNC_QUERY, pick_letter(), k == 0,
                                        k == len - 1 || $urandom_range(0, 19) == 0));
            end
            else if (kind <= 17)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_item(pack_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
            else if (kind == 18)
                send_run(FUNC_QUERY, $urandom_range(1, 10), 1'b1, 1'b0);
            else
                send_run(FUNC_QUERY, $urandom_range(1, 10), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        hold_req   <= 1'b0;
        cfg_table  = SCORE_TABLE_RST;
        cfg_open   = int'(GAP_OPEN_RST);
        cfg_ext    = int'(GAP_EXTEND_RST);
        subj_len   = 0;
        ovf_seen   = 1'b0;
        reset_rows();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_subject();
        test_basic_letters();
        test_register_extremes();
        test_subject_overflow();
        test_score_saturation();
        test_output_backpressure();
        test_random_traffic();

        settle();
        if (pending_scores.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results expected but never seen", $time,
                     pending_scores.size());
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
